FILE: rtl/pointer_handle_table_core_defines.svh
// Assertion macros shared by the handle table RTL.
`ifndef POINTER_HANDLE_TABLE_CORE_DEFINES_SVH
`define POINTER_HANDLE_TABLE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pht_pkg.sv
`default_nettype none
package pht_pkg;

  localparam int OP_W  = 3;
  localparam int NS_W  = 8;
  localparam int PTR_W = 64;
  localparam int HDL_W = 32;
  localparam int ST_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE_H = 3'd1,
    OP_FREE_P = 3'd2,
    OP_H2P    = 3'd3,
    OP_P2H    = 3'd4
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_INVAL = 2'd1,
    ST_FULL  = 2'd2,
    ST_NOENT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMP_FREE   = 2'd0,
    CMP_MATCH  = 2'd1,
    CMP_HANDLE = 2'd2
  } cmp_mode_t;

endpackage
`default_nettype wire

FILE: rtl/pht_if.sv
`default_nettype none
interface pht_req_if;
  logic                          valid;
  logic                          ready;
  logic [pht_pkg::OP_W-1:0]      opcode;
  logic [pht_pkg::NS_W-1:0]      req_ns;
  logic [pht_pkg::PTR_W-1:0]     req_pointer;
  logic [pht_pkg::HDL_W-1:0]     req_handle;

  modport source (output valid, opcode, req_ns, req_pointer, req_handle, input ready);
  modport sink   (input valid, opcode, req_ns, req_pointer, req_handle, output ready);
endinterface

interface pht_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pht_pkg::ST_W-1:0]      status;
  logic [pht_pkg::HDL_W-1:0]     out_handle;
  logic [pht_pkg::PTR_W-1:0]     out_pointer;

  modport source (output valid, status, out_handle, out_pointer, input ready);
  modport sink   (input valid, status, out_handle, out_pointer, output ready);
endinterface
`default_nettype wire

FILE: rtl/pht_mem.sv
`default_nettype none
module pht_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 73
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/pht_cmp.sv
`default_nettype none
module pht_cmp #(
  parameter int NS_BITS  = 8,
  parameter int PTR_BITS = 64
) (
  input  wire pht_pkg::cmp_mode_t           mode,
  input  wire logic [NS_BITS+PTR_BITS:0]    entry,
  input  wire logic [NS_BITS-1:0]           key_ns,
  input  wire logic [PTR_BITS-1:0]          key_ptr,
  output logic                              hit
);

  logic                used;
  logic [NS_BITS-1:0]  ns;
  logic [PTR_BITS-1:0] ptr;

  assign used = entry[NS_BITS+PTR_BITS];
  assign ns   = entry[NS_BITS+PTR_BITS-1:PTR_BITS];
  assign ptr  = entry[PTR_BITS-1:0];

  always_comb begin
    case (mode)
      pht_pkg::CMP_FREE:   hit = !used;
      pht_pkg::CMP_MATCH:  hit = used && (ns == key_ns) && (ptr == key_ptr);
      pht_pkg::CMP_HANDLE: hit = used && (ns == key_ns) && (ptr != '0);
      default:             hit = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/pointer_handle_table_core.sv
// Pointer handle table core.
// Requests arrive on in_req (valid/ready); each transfer carries an opcode, a
// namespace tag, a pointer and a handle. Exactly one result per request leaves
// on out_rsp (valid/ready) with a status, a handle and a pointer.
// After reset the block runs a clearing pass over every slot of the slot
// memory, holding in_req.ready low, then waits for requests.
// One request is in work at a time; in_req.ready is high only while idle.
// Null pointers, null handles and rejected arguments are settled in S_DECODE,
// which passes straight to S_DONE. A handle-based operation reads its slot
// once and is checked in S_HCHECK. Allocation and pointer lookups step one
// slot per cycle through the single read port of the slot memory and the
// shared compare unit, over at most DEPTH slots.
// in_req.ready rises in the cycle after a result moves into the output
// register.
// The result sits in an output register; if the receiver stalls, the next
// request is still taken and worked, and its result waits in the core until
// the output register frees.

`default_nettype none
`include "pointer_handle_table_core_defines.svh"
module pointer_handle_table_core #(
  parameter int DEPTH    = 256,
  parameter int NS_BITS  = 8,
  parameter int PTR_BITS = 64
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  pht_req_if.sink      in_req,
  pht_rsp_if.source    out_rsp
);

  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = $clog2(DEPTH + 1);
  localparam int IDX_BITS = pht_pkg::HDL_W - NS_BITS;
  localparam int NSW      = (NS_BITS > pht_pkg::NS_W) ? NS_BITS : pht_pkg::NS_W;
  localparam int EW       = 1 + NS_BITS + PTR_BITS;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_HCHECK, S_SCAN, S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [pht_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [pht_pkg::NS_W-1:0]     ns_r, ns_nxt;
  logic [PTR_BITS-1:0]          ptr_r, ptr_nxt;
  logic [pht_pkg::HDL_W-1:0]    hdl_r, hdl_nxt;
  pht_pkg::cmp_mode_t           mode_r, mode_nxt;
  logic [AW-1:0]                addr_r, addr_nxt;
  logic [CW-1:0]                issued_r, issued_nxt;
  logic                         chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]                chk_idx_r, chk_idx_nxt;
  logic [CW-1:0]                used_cnt_r, used_cnt_nxt;
  logic [AW-1:0]                srch_r, srch_nxt;
  pht_pkg::status_t             res_status_r, res_status_nxt;
  logic [pht_pkg::HDL_W-1:0]    res_handle_r, res_handle_nxt;
  logic [pht_pkg::PTR_W-1:0]    res_ptr_r, res_ptr_nxt;
  logic                         out_vld_r, out_vld_nxt;
  pht_pkg::status_t             out_status_r, out_status_nxt;
  logic [pht_pkg::HDL_W-1:0]    out_handle_r, out_handle_nxt;
  logic [pht_pkg::PTR_W-1:0]    out_ptr_r, out_ptr_nxt;

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [EW-1:0]                mem_wdata;
  logic [AW-1:0]                mem_raddr;
  logic [EW-1:0]                mem_rdata;
  logic                         hit;

  logic                         in_acc;
  logic [NSW-1:0]               ns_ext;
  logic [NS_BITS-1:0]           key_ns;
  logic                         ns_bad;
  logic                         hdl_bad;
  logic [EW-1:0]                empty_entry;

  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [pht_pkg::HDL_W-1:0] make_handle(input logic [NS_BITS-1:0] ns,
                                                            input logic [AW-1:0] idx);
    return {ns, IDX_BITS'(idx)};
  endfunction

  assign in_acc      = in_req.valid && in_req.ready;
  assign ns_ext      = NSW'(ns_r);
  assign key_ns      = ns_ext[NS_BITS-1:0];
  assign ns_bad      = !(ns_ext < NSW'((32'd1 << NS_BITS) - 32'd1));
  assign hdl_bad     = (NSW'(hdl_r[pht_pkg::HDL_W-1:IDX_BITS]) != ns_ext) ||
                       (32'(hdl_r[IDX_BITS-1:0]) >= 32'(DEPTH));
  assign empty_entry = {1'b0, {NS_BITS{1'b1}}, {PTR_BITS{1'b0}}};

  pht_mem #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pht_cmp #(
    .NS_BITS  (NS_BITS),
    .PTR_BITS (PTR_BITS)
  ) u_cmp (
    .mode    (mode_r),
    .entry   (mem_rdata),
    .key_ns  (key_ns),
    .key_ptr (ptr_r),
    .hit     (hit)
  );

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    ns_nxt         = ns_r;
    ptr_nxt        = ptr_r;
    hdl_nxt        = hdl_r;
    mode_nxt       = mode_r;
    addr_nxt       = addr_r;
    issued_nxt     = issued_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    used_cnt_nxt   = used_cnt_r;
    srch_nxt       = srch_r;
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    res_ptr_nxt    = res_ptr_r;
    out_vld_nxt    = out_vld_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_ptr_nxt    = out_ptr_r;
    mem_we         = 1'b0;
    mem_waddr      = chk_idx_r;
    mem_wdata      = empty_entry;
    mem_raddr      = addr_r;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        addr_nxt  = next_idx(addr_r);
        if (addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_req.opcode;
          ns_nxt    = in_req.req_ns;
          ptr_nxt   = in_req.req_pointer[PTR_BITS-1:0];
          hdl_nxt   = in_req.req_handle;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        res_status_nxt = pht_pkg::ST_OK;
        res_handle_nxt = '0;
        res_ptr_nxt    = '0;
        state_nxt      = S_DONE;
        addr_nxt       = '0;
        issued_nxt     = '0;
        chk_vld_nxt    = 1'b0;
        case (op_r)
          pht_pkg::OP_ALLOC: begin
            if (ptr_r == '0) begin
              res_status_nxt = pht_pkg::ST_OK;
            end else if (ns_bad) begin
              res_status_nxt = pht_pkg::ST_INVAL;
            end else if (used_cnt_r == CW'(DEPTH)) begin
              res_status_nxt = pht_pkg::ST_FULL;
            end else begin
              addr_nxt  = srch_r;
              mode_nxt  = pht_pkg::CMP_FREE;
              state_nxt = S_SCAN;
            end
          end
          pht_pkg::OP_FREE_P, pht_pkg::OP_P2H: begin
            if (ptr_r == '0) begin
              res_status_nxt = pht_pkg::ST_OK;
            end else if (ns_bad) begin
              res_status_nxt = pht_pkg::ST_INVAL;
            end else begin
              mode_nxt  = pht_pkg::CMP_MATCH;
              state_nxt = S_SCAN;
            end
          end
          pht_pkg::OP_FREE_H, pht_pkg::OP_H2P: begin
            if (hdl_r == '0) begin
              res_status_nxt = pht_pkg::ST_OK;
            end else if (ns_bad || hdl_bad) begin
              res_status_nxt = pht_pkg::ST_INVAL;
            end else begin
              mem_raddr = hdl_r[AW-1:0];
              mode_nxt  = pht_pkg::CMP_HANDLE;
              state_nxt = S_HCHECK;
            end
          end
          default: begin
            res_status_nxt = pht_pkg::ST_INVAL;
          end
        endcase
      end
      S_HCHECK: begin
        state_nxt = S_DONE;
        mem_waddr = hdl_r[AW-1:0];
        if (!hit) begin
          res_status_nxt = pht_pkg::ST_INVAL;
        end else if (op_r == pht_pkg::OP_FREE_H) begin
          mem_we = 1'b1;
          if (used_cnt_r != '0) begin
            used_cnt_nxt = used_cnt_r - 1'b1;
          end
        end else begin
          res_ptr_nxt = pht_pkg::PTR_W'(mem_rdata[PTR_BITS-1:0]);
        end
      end
      S_SCAN: begin
        if (chk_vld_r && hit) begin
          state_nxt = S_DONE;
          if (mode_r == pht_pkg::CMP_FREE) begin
            mem_we         = 1'b1;
            mem_wdata      = {1'b1, key_ns, ptr_r};
            used_cnt_nxt   = used_cnt_r + 1'b1;
            srch_nxt       = next_idx(chk_idx_r);
            res_handle_nxt = make_handle(key_ns, chk_idx_r);
          end else if (op_r == pht_pkg::OP_FREE_P) begin
            mem_we = 1'b1;
            if (used_cnt_r != '0) begin
              used_cnt_nxt = used_cnt_r - 1'b1;
            end
          end else begin
            res_handle_nxt = make_handle(key_ns, chk_idx_r);
          end
        end else if (chk_vld_r && (issued_r == CW'(DEPTH))) begin
          state_nxt      = S_DONE;
          res_status_nxt = (mode_r == pht_pkg::CMP_FREE) ? pht_pkg::ST_FULL
                                                          : pht_pkg::ST_NOENT;
        end else if (issued_r != CW'(DEPTH)) begin
          chk_idx_nxt = addr_r;
          chk_vld_nxt = 1'b1;
          addr_nxt    = next_idx(addr_r);
          issued_nxt  = issued_r + 1'b1;
        end else begin
          chk_vld_nxt = 1'b0;
        end
      end
      S_DONE: begin
        if (!out_vld_r || out_rsp.ready) begin
          out_vld_nxt    = 1'b1;
          out_status_nxt = res_status_r;
          out_handle_nxt = res_handle_r;
          out_ptr_nxt    = res_ptr_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      addr_r     <= '0;
      issued_r   <= '0;
      chk_vld_r  <= 1'b0;
      used_cnt_r <= '0;
      srch_r     <= '0;
      out_vld_r  <= 1'b0;
      mode_r     <= pht_pkg::CMP_FREE;
    end else begin
      state_r    <= state_nxt;
      addr_r     <= addr_nxt;
      issued_r   <= issued_nxt;
      chk_vld_r  <= chk_vld_nxt;
      used_cnt_r <= used_cnt_nxt;
      srch_r     <= srch_nxt;
      out_vld_r  <= out_vld_nxt;
      mode_r     <= mode_nxt;
    end
    op_r         <= op_nxt;
    ns_r         <= ns_nxt;
    ptr_r        <= ptr_nxt;
    hdl_r        <= hdl_nxt;
    chk_idx_r    <= chk_idx_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    res_ptr_r    <= res_ptr_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_ptr_r    <= out_ptr_nxt;
  end

  assign in_req.ready        = (state_r == S_IDLE);
  assign out_rsp.valid       = out_vld_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.out_handle  = out_handle_r;
  assign out_rsp.out_pointer = out_ptr_r;

  `PHT_ASSERT_NOW(a_used_cnt_range, 1'b1, used_cnt_r <= CW'(DEPTH), "used count exceeds table depth")
  `PHT_ASSERT_NOW(a_no_write_idle, state_r == S_IDLE, !mem_we, "slot memory written while idle")
  `PHT_ASSERT_NEXT(a_alloc_count, (state_r == S_SCAN) && chk_vld_r && hit && (mode_r == pht_pkg::CMP_FREE), used_cnt_r == CW'($past(used_cnt_r) + 1'b1), "allocation did not bump used count")
  `PHT_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_req.ready, "request accepted while another is in work")

endmodule
`default_nettype wire

FILE: tb/sv/tb_pointer_handle_table_core.sv
module tb_pointer_handle_table_core;
  import pht_pkg::*;

  localparam int DEPTH = 256;
  localparam int IDX_BITS = HDL_W - NS_W;
  localparam logic [NS_W-1:0] NS_INVALID = '1;
  localparam logic [NS_W-1:0] NS_TOP = NS_INVALID - 1;
  localparam logic [OP_W-1:0] OP_UNDEF_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_UNDEF_6 = 3'd6;
  localparam logic [PTR_W-1:0] PTR_ONES = '1;
  localparam logic [PTR_W-1:0] PTR_TOP = {1'b1, {(PTR_W-1){1'b0}}};
  localparam int RANDOM_PER_PHASE = 400;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 4 * (HOLD_CYCLES + DEPTH + 16);

  typedef struct packed {
    status_t          status;
    logic [HDL_W-1:0] out_handle;
    logic [PTR_W-1:0] out_pointer;
  } table_result_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [NS_W-1:0]  ns;
    logic [PTR_W-1:0] ptr;
    logic [HDL_W-1:0] h;
    logic             known;
    table_result_t    res;
  } directed_row_t;

  localparam table_result_t RES_NULL = '{ST_OK, '0, '0};
  localparam table_result_t RES_INVAL = '{ST_INVAL, '0, '0};
  localparam table_result_t RES_NOENT = '{ST_NOENT, '0, '0};

  localparam int NUM_DIRECTED = 25;
  localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
    '{OP_ALLOC,   8'h00,      64'h0,    32'h0,        1'b1, RES_NULL},
    '{OP_ALLOC,   NS_INVALID, 64'h1,    32'h0,        1'b1, RES_INVAL},
    '{OP_ALLOC,   8'h00,      PTR_ONES, 32'h0,        1'b1, RES_NULL},
    '{OP_ALLOC,   NS_TOP,     64'h1,    32'h0,        1'b1, '{ST_OK, 32'hFE00_0001, '0}},
    '{OP_ALLOC,   8'h01,      PTR_TOP,  32'h0,        1'b1, '{ST_OK, 32'h0100_0002, '0}},
    '{OP_H2P,     NS_TOP,     64'h0,    32'hFE00_0001, 1'b0, RES_NULL},
    '{OP_H2P,     8'h00,      64'h0,    32'h0,        1'b1, RES_NULL},
    '{OP_H2P,     8'h01,      64'h0,    32'hFE00_0001, 1'b1, RES_INVAL},
    '{OP_H2P,     NS_TOP,     64'h0,    32'hFE00_0100, 1'b1, RES_INVAL},
    '{OP_H2P,     NS_TOP,     64'h0,    32'hFEFF_FFFF, 1'b1, RES_INVAL},
    '{OP_H2P,     NS_INVALID, 64'h0,    32'hFF00_0001, 1'b1, RES_INVAL},
    '{OP_P2H,     8'h01,      PTR_TOP,  32'h0,        1'b0, RES_NULL},
    '{OP_P2H,     8'h01,      64'h1,    32'h0,        1'b1, RES_NOENT},
    '{OP_P2H,     8'h00,      64'h0,    32'h0,        1'b1, RES_NULL},
    '{OP_P2H,     NS_INVALID, 64'h5,    32'h0,        1'b1, RES_INVAL},
    '{OP_FREE_P,  8'h01,      PTR_TOP,  32'h0,        1'b0, RES_NULL},
    '{OP_FREE_P,  8'h01,      PTR_TOP,  32'h0,        1'b1, RES_NOENT},
    '{OP_FREE_H,  NS_TOP,     64'h0,    32'hFE00_0001, 1'b0, RES_NULL},
    '{OP_FREE_H,  NS_TOP,     64'h0,    32'hFE00_0001, 1'b1, RES_INVAL},
    '{OP_FREE_H,  8'h00,      64'h0,    32'h0,        1'b1, RES_NULL},
    '{OP_FREE_P,  8'h00,      64'h0,    32'h0,        1'b1, RES_NULL},
    '{OP_UNDEF_5, 8'h00,      64'h1,    32'h1,        1'b1, RES_INVAL},
    '{OP_UNDEF_6, NS_INVALID, PTR_ONES, 32'hFFFF_FFFF, 1'b1, RES_INVAL},
    '{OP_FREE_H,  8'h00,      64'h0,    32'hFF00_0000, 1'b1, RES_INVAL},
    '{OP_ALLOC,   8'h00,      64'h1234, 32'h0,        1'b0, RES_NULL}
  };

  logic clk = 1'b0;
  logic rst_n;

  pht_req_if req_ch();
  pht_rsp_if rsp_ch();

  pointer_handle_table_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_rsp(rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [NS_W-1:0]  slot_ns   [DEPTH];
  logic [PTR_W-1:0] slot_ptr  [DEPTH];
  bit               slot_used [DEPTH];
  int used_cnt;
  int search_pos;
  int peak_used;

  table_result_t pending_results [$];
  int fail_count;
  int sent_count;
  int status_seen [4];
  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_off_req;
  int quiet_cycles = 0;
  bit filling;
  int full_run;

  function automatic int find_pointer(logic [NS_W-1:0] ns, logic [PTR_W-1:0] ptr);
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_used[i] && slot_ns[i] == ns && slot_ptr[i] == ptr) return i;
    end
    return -1;
  endfunction

  function automatic int handle_slot(logic [HDL_W-1:0] h, logic [NS_W-1:0] ns);
    int idx;
    if (h[HDL_W-1:IDX_BITS] != ns) return -1;
    idx = int'(h[IDX_BITS-1:0]);
    if (idx >= DEPTH) return -1;
    if (!slot_used[idx] || slot_ns[idx] != ns || slot_ptr[idx] == '0) return -1;
    return idx;
  endfunction

  function automatic void free_slot(int idx);
    slot_ptr[idx] = '0;
    slot_ns[idx] = NS_INVALID;
    slot_used[idx] = 1'b0;
    if (used_cnt > 0) used_cnt--;
  endfunction

  function automatic table_result_t apply_table_op(logic [OP_W-1:0] op, logic [NS_W-1:0] ns,
                                                   logic [PTR_W-1:0] ptr, logic [HDL_W-1:0] h);
    table_result_t r;
    int idx;
    r = RES_NULL;
    idx = -1;
    case (op)
      OP_ALLOC: begin
        if (ptr != '0) begin
          if (ns == NS_INVALID) begin
            r.status = ST_INVAL;
          end else if (used_cnt >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (int k = 0; k < DEPTH; k++) begin
              if (idx < 0 && !slot_used[(search_pos + k) % DEPTH]) idx = (search_pos + k) % DEPTH;
            end
            slot_ptr[idx] = ptr;
            slot_ns[idx] = ns;
            slot_used[idx] = 1'b1;
            used_cnt++;
            search_pos = (idx + 1) % DEPTH;
            r.out_handle = {ns, IDX_BITS'(idx)};
          end
        end
      end
      OP_FREE_H, OP_H2P: begin
        if (h != '0) begin
          if (ns != NS_INVALID) idx = handle_slot(h, ns);
          if (idx < 0) r.status = ST_INVAL;
          else if (op == OP_FREE_H) free_slot(idx);
          else r.out_pointer = slot_ptr[idx];
        end
      end
      OP_FREE_P, OP_P2H: begin
        if (ptr != '0) begin
          if (ns == NS_INVALID) begin
            r.status = ST_INVAL;
          end else begin
            idx = find_pointer(ns, ptr);
            if (idx < 0) r.status = ST_NOENT;
            else if (op == OP_FREE_P) free_slot(idx);
            else r.out_handle = {ns, IDX_BITS'(idx)};
          end
        end
      end
      default: r.status = ST_INVAL;
    endcase
    if (used_cnt > peak_used) peak_used = used_cnt;
    return r;
  endfunction

  function automatic int pick_used_slot();
    int s;
    if (used_cnt == 0) return -1;
    s = $urandom_range(0, DEPTH - 1);
    while (!slot_used[s]) s = (s + 1) % DEPTH;
    return s;
  endfunction

  function automatic logic [PTR_W-1:0] pick_pointer();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 45) return PTR_W'($urandom_range(1, 6));
    return {$urandom, $urandom};
  endfunction

  task automatic make_random_request(output logic [OP_W-1:0] op, output logic [NS_W-1:0] ns,
                                     output logic [PTR_W-1:0] ptr, output logic [HDL_W-1:0] h);
    int roll;
    int s;
    int kind;
    op = OP_ALLOC;
    ptr = {$urandom, $urandom};
    h = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 40) ns = NS_W'($urandom_range(0, 2));
    else if (roll < 50) ns = NS_TOP;
    else if (roll < 95) ns = NS_W'($urandom_range(0, 254));
    else ns = NS_INVALID;
    s = pick_used_slot();
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      op = OP_W'($urandom_range(0, 7));
      ns = NS_W'($urandom_range(0, 255));
    end else if (roll < 14 && s >= 0) begin
      op = $urandom_range(0, 1) ? OP_FREE_H : OP_H2P;
      ns = slot_ns[s];
      h = {slot_ns[s], IDX_BITS'(s)};
      if ($urandom_range(0, 1)) h[$urandom_range(0, HDL_W - 1)] ^= 1'b1;
      else ns = ns ^ NS_W'($urandom_range(1, 255));
    end else if (s < 0 || $urandom_range(0, 99) < (filling ? 70 : 10)) begin
      op = OP_ALLOC;
      ptr = pick_pointer();
    end else begin
      kind = $urandom_range(0, 3);
      if (filling && kind < 2 && $urandom_range(0, 99) < 75) kind += 2;
      if (!filling && kind >= 2 && $urandom_range(0, 99) < 50) kind -= 2;
      ns = slot_ns[s];
      case (kind)
        0: op = OP_FREE_H;
        1: op = OP_FREE_P;
        2: op = OP_H2P;
        default: op = OP_P2H;
      endcase
      if (op == OP_FREE_H || op == OP_H2P) begin
        h = {slot_ns[s], IDX_BITS'(s)};
      end else begin
        ptr = ($urandom_range(0, 99) < 15) ? pick_pointer() : slot_ptr[s];
      end
    end
  endtask

  task automatic send_request(logic [OP_W-1:0] op, logic [NS_W-1:0] ns, logic [PTR_W-1:0] ptr,
                              logic [HDL_W-1:0] h, logic known, table_result_t known_res);
    table_result_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.req_ns <= ns;
    req_ch.req_pointer <= ptr;
    req_ch.req_handle <= h;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predicted = apply_table_op(op, ns, ptr, h);
    pending_results.push_back(known ? known_res : predicted);
    sent_count++;
  endtask

  task automatic wait_results_drained();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checker: every transfer on the output is matched against the oldest expectation.
  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d handle %h pointer %h", $time,
                 rsp_ch.status, rsp_ch.out_handle, rsp_ch.out_pointer);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        status_seen[rsp_ch.status]++;
        if (rsp_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_ch.status);
          fail_count++;
        end
        if (rsp_ch.out_handle !== want.out_handle) begin
          $display("%0t: handle expected %h actual %h", $time, want.out_handle,
                   rsp_ch.out_handle);
          fail_count++;
        end
        if (rsp_ch.out_pointer !== want.out_pointer) begin
          $display("%0t: pointer expected %h actual %h", $time, want.out_pointer,
                   rsp_ch.out_pointer);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  initial begin
    logic [OP_W-1:0]  op;
    logic [NS_W-1:0]  ns;
    logic [PTR_W-1:0] ptr;
    logic [HDL_W-1:0] h;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_ALLOC;
    req_ch.req_ns = '0;
    req_ch.req_pointer = '0;
    req_ch.req_handle = '0;
    hold_off_req = 1'b0;
    tx_idle_pct = 31;
    rx_idle_pct = 74;
    for (int i = 0; i < DEPTH; i++) begin
      slot_ns[i] = NS_INVALID;
      slot_ptr[i] = '0;
      slot_used[i] = 1'b0;
    end
    used_cnt = 0;
    search_pos = 0;
    peak_used = 0;
    filling = 1'b1;
    full_run = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      send_request(DIRECTED[i].op, DIRECTED[i].ns, DIRECTED[i].ptr, DIRECTED[i].h,
                   DIRECTED[i].known, DIRECTED[i].res);
    end
    wait_results_drained();

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 74 : 0;
      rx_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 31 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // A long receiver stall while requests keep coming backs the block up to its input.
        if (phase == 0 && n == 150) hold_off_req = 1'b1;
        make_random_request(op, ns, ptr, h);
        send_request(op, ns, ptr, h, 1'b0, RES_NULL);
        if (filling && used_cnt == DEPTH) full_run++;
        if (full_run >= 20) begin
          filling = 1'b0;
          full_run = 0;
        end
        if (!filling && used_cnt < 16) filling = 1'b1;
      end
      wait_results_drained();
    end

    repeat (DEPTH + 8) @(posedge clk);
    $display("Covered %0d requests (%0d directed): %0d ok, %0d invalid, %0d full, %0d not found.",
             sent_count, NUM_DIRECTED, status_seen[ST_OK], status_seen[ST_INVAL],
             status_seen[ST_FULL], status_seen[ST_NOENT]);
    $display("Table occupancy peaked at %0d of %0d slots; one receiver stall lasted %0d cycles.",
             peak_used, DEPTH, HOLD_CYCLES);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pht_pkg.sv
rtl/pht_if.sv
rtl/pht_mem.sv
rtl/pht_cmp.sv
rtl/pointer_handle_table_core.sv
tb/sv/tb_pointer_handle_table_core.sv
